@@ src/swrr_pkg.sv @@
package swrr_pkg;

    // server set
    localparam int MAX_SERVERS = 4;
    localparam int WEIGHT_REGS = 4;
    localparam int IDX_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

    // field widths
    localparam int COUNT_W  = 3;
    localparam int WEIGHT_W = 8;
    localparam int TAG_W    = 8;
    localparam int CHOSEN_W = 2;

    // running weight arithmetic
    localparam int RW_W    = 11;
    localparam int TOTAL_W = $clog2(MAX_SERVERS * ((1 << WEIGHT_W) - 1) + 1);
    localparam int SUM_W   = ((TOTAL_W > RW_W) ? TOTAL_W : RW_W) + 2;

    localparam logic signed [SUM_W-1:0] RW_HI = SUM_W'((1 << (RW_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] RW_LO = SUM_W'(-(1 << (RW_W - 1)));

    localparam logic [COUNT_W-1:0]  MAX_COUNT      = COUNT_W'(MAX_SERVERS);
    localparam logic [WEIGHT_W-1:0] WEIGHT_DEFAULT = WEIGHT_W'(1);

    // register map
    localparam int NUM_REGS   = 1 + WEIGHT_REGS;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int ADDR_W     = REG_IDX_W + 2;
    localparam int DATA_W     = 32;

    localparam logic [REG_IDX_W-1:0] REG_SERVER_COUNT = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_WEIGHT_0     = REG_IDX_W'(1);

    typedef logic [WEIGHT_W-1:0]      weight_t;
    typedef logic signed [RW_W-1:0]   rw_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic trim;
        logic publish;
    } swrr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
        logic last;
        logic out_free;
    } swrr_sts_t;

    function automatic sum_t rw_to_sum(input rw_t v);
        return SUM_W'(v);
    endfunction

    function automatic sum_t total_to_sum(input logic [TOTAL_W-1:0] v);
        return sum_t'({1'b0, v});
    endfunction

    function automatic logic [TOTAL_W-1:0] weight_to_total(input weight_t w);
        return TOTAL_W'(w);
    endfunction

    // saturate to the running weight range
    function automatic rw_t clamp_rw(input sum_t v);
        sum_t r;
        r = v;
        if (v > RW_HI) begin
            r = RW_HI;
        end else if (v < RW_LO) begin
            r = RW_LO;
        end
        return rw_t'(r[RW_W-1:0]);
    endfunction

    function automatic logic [COUNT_W-1:0] idx_to_count(input logic [IDX_W-1:0] idx);
        logic [COUNT_W+IDX_W-1:0] t;
        t = '0;
        t[IDX_W-1:0] = idx;
        return t[COUNT_W-1:0];
    endfunction

    function automatic logic [CHOSEN_W-1:0] idx_to_chosen(input logic [IDX_W-1:0] idx);
        logic [CHOSEN_W+IDX_W-1:0] t;
        t = '0;
        t[IDX_W-1:0] = idx;
        return t[CHOSEN_W-1:0];
    endfunction

endpackage

@@ src/smooth_weighted_round_robin.sv @@
// smooth weighted round robin picker: each request item adds every active server's
// weight to its running weight, picks the largest running weight (lowest index wins
// ties) and takes the total of active weights back off the winner; the result carries
// the chosen server and the request tag, or no_server when server_count is zero.
// running weights persist between items and clear only at reset. one item is in
// work at a time: an item is taken in, then stepped once per active server through
// the single running-weight adder, then the winner's subtraction is done, then the
// output register is loaded; with no server active the item goes straight from
// intake to loading the output register. the output register lets the next item
// be accepted while a result still waits on m_ready; a finished item holds in the
// controller only while that register is still full.
// configuration is through an apb-style port, registers at byte address 4*i:
// server_count, then weight_0..3.
module smooth_weighted_round_robin (
    input  logic                          aclk,
    input  logic                          aresetn,

    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swrr_pkg::ADDR_W-1:0]   paddr,
    input  logic [swrr_pkg::DATA_W-1:0]   pwdata,
    output logic [swrr_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,

    // request items
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [swrr_pkg::TAG_W-1:0]    s_request_tag,

    // result items
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [swrr_pkg::CHOSEN_W-1:0] m_chosen_server,
    output logic [swrr_pkg::TAG_W-1:0]    m_tag_out,
    output logic                          m_no_server
);

    logic [swrr_pkg::COUNT_W-1:0] server_count;
    swrr_pkg::weight_t            weight [swrr_pkg::WEIGHT_REGS];
    swrr_pkg::swrr_cmd_t          cmd;
    swrr_pkg::swrr_sts_t          sts;

    // writes complete in the access cycle, no wait states
    assign pready = 1'b1;

    swrr_regs u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .server_count (server_count),
        .weight       (weight)
    );

    // sequencer: accept, one step per active server, trim the winner, publish; an empty set goes straight to publish
    swrr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // running weights, max search, total and the output register
    swrr_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .server_count    (server_count),
        .weight          (weight),
        .s_request_tag   (s_request_tag),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_chosen_server (m_chosen_server),
        .m_tag_out       (m_tag_out),
        .m_no_server     (m_no_server)
    );

`ifndef NO_ASSERTIONS
    // an empty server set always reports server zero
    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_no_server |-> m_chosen_server == '0)
        else $error("no_server result with nonzero chosen_server");

    // at most one item in work: acceptance drops ready for the next cycle
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready held after item accepted");

    // a result is published only from the finishing step, never while idle
    a_publish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while controller idle");
`endif

endmodule

@@ src/swrr_regs.sv @@
module swrr_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [swrr_pkg::ADDR_W-1:0]          paddr,
    input  logic [swrr_pkg::DATA_W-1:0]          pwdata,
    output logic [swrr_pkg::DATA_W-1:0]          prdata,
    output logic [swrr_pkg::COUNT_W-1:0]         server_count,
    output swrr_pkg::weight_t                    weight [swrr_pkg::WEIGHT_REGS]
);

    logic [swrr_pkg::COUNT_W-1:0]   count_reg;
    logic [swrr_pkg::COUNT_W-1:0]   count_next;
    swrr_pkg::weight_t              weight_reg  [swrr_pkg::WEIGHT_REGS];
    swrr_pkg::weight_t              weight_next [swrr_pkg::WEIGHT_REGS];
    logic [swrr_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           wr_en;

    assign reg_idx = paddr[swrr_pkg::ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;

    always_comb begin
        count_next = count_reg;
        for (int k = 0; k < swrr_pkg::WEIGHT_REGS; k++) begin
            weight_next[k] = weight_reg[k];
        end
        if (wr_en) begin
            if (reg_idx == swrr_pkg::REG_SERVER_COUNT) begin
                count_next = pwdata[swrr_pkg::COUNT_W-1:0];
            end
            for (int k = 0; k < swrr_pkg::WEIGHT_REGS; k++) begin
                // weight registers of servers beyond the set are ignored
                if ((reg_idx == swrr_pkg::REG_IDX_W'(swrr_pkg::REG_WEIGHT_0 + k))
                    && (k < swrr_pkg::MAX_SERVERS)) begin
                    weight_next[k] = pwdata[swrr_pkg::WEIGHT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            for (int k = 0; k < swrr_pkg::WEIGHT_REGS; k++) begin
                weight_reg[k] <= swrr_pkg::WEIGHT_DEFAULT;
            end
        end else begin
            count_reg <= count_next;
            for (int k = 0; k < swrr_pkg::WEIGHT_REGS; k++) begin
                weight_reg[k] <= weight_next[k];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == swrr_pkg::REG_SERVER_COUNT) begin
            prdata = swrr_pkg::DATA_W'(count_reg);
        end
        for (int k = 0; k < swrr_pkg::WEIGHT_REGS; k++) begin
            if (reg_idx == swrr_pkg::REG_IDX_W'(swrr_pkg::REG_WEIGHT_0 + k)) begin
                prdata = swrr_pkg::DATA_W'(weight_reg[k]);
            end
        end
    end

    assign server_count = count_reg;

    always_comb begin
        for (int k = 0; k < swrr_pkg::WEIGHT_REGS; k++) begin
            weight[k] = weight_reg[k];
        end
    end

endmodule

@@ src/swrr_ctrl.sv @@
module swrr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  swrr_pkg::swrr_sts_t sts,
    output swrr_pkg::swrr_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_STEP = 4'b0010,
        ST_TRIM = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.count_zero ? ST_DONE : ST_STEP;
                end
            end
            ST_STEP: begin
                cmd.step = 1'b1;
                if (sts.last) begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM: begin
                cmd.trim   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

@@ src/swrr_dp.sv @@
module swrr_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  swrr_pkg::swrr_cmd_t           cmd,
    output swrr_pkg::swrr_sts_t           sts,
    input  logic [swrr_pkg::COUNT_W-1:0]  server_count,
    input  swrr_pkg::weight_t             weight [swrr_pkg::WEIGHT_REGS],
    input  logic [swrr_pkg::TAG_W-1:0]    s_request_tag,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [swrr_pkg::CHOSEN_W-1:0] m_chosen_server,
    output logic [swrr_pkg::TAG_W-1:0]    m_tag_out,
    output logic                          m_no_server
);

    swrr_pkg::rw_t                  rw_reg [swrr_pkg::MAX_SERVERS];
    logic [swrr_pkg::IDX_W-1:0]     idx_reg;
    logic [swrr_pkg::IDX_W-1:0]     pick_reg;
    swrr_pkg::rw_t                  best_reg;
    logic [swrr_pkg::TOTAL_W-1:0]   total_reg;
    logic [swrr_pkg::COUNT_W-1:0]   n_reg;
    logic                           empty_reg;
    logic [swrr_pkg::TAG_W-1:0]     tag_reg;

    logic                           out_valid_reg;
    logic [swrr_pkg::CHOSEN_W-1:0]  out_chosen_reg;
    logic [swrr_pkg::TAG_W-1:0]     out_tag_reg;
    logic                           out_none_reg;

    logic [swrr_pkg::IDX_W-1:0]     rw_addr;
    swrr_pkg::rw_t                  rw_rd;
    swrr_pkg::weight_t              w_cur;
    swrr_pkg::rw_t                  rw_step;
    swrr_pkg::rw_t                  rw_trim;
    logic                           better;
    logic [swrr_pkg::COUNT_W-1:0]   n_load;

    // one shared read of the running weights: current server, or the winner when trimming
    assign rw_addr = cmd.trim ? pick_reg : idx_reg;
    assign rw_rd   = rw_reg[rw_addr];

    // servers without a weight register keep weight one
    always_comb begin
        w_cur = swrr_pkg::WEIGHT_DEFAULT;
        for (int k = 0; k < swrr_pkg::WEIGHT_REGS; k++) begin
            if (idx_reg == k) begin
                w_cur = weight[k];
            end
        end
    end

    assign rw_step = swrr_pkg::clamp_rw(swrr_pkg::rw_to_sum(rw_rd)
                     + swrr_pkg::total_to_sum(swrr_pkg::weight_to_total(w_cur)));
    assign rw_trim = swrr_pkg::clamp_rw(swrr_pkg::rw_to_sum(rw_rd)
                     - swrr_pkg::total_to_sum(total_reg));
    assign better  = (idx_reg == '0) || (rw_step > best_reg);

    assign n_load = (server_count > swrr_pkg::MAX_COUNT) ? swrr_pkg::MAX_COUNT : server_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < swrr_pkg::MAX_SERVERS; k++) begin
                rw_reg[k] <= '0;
            end
        end else if (cmd.step) begin
            rw_reg[idx_reg] <= rw_step;
        end else if (cmd.trim) begin
            rw_reg[pick_reg] <= rw_trim;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            tag_reg   <= s_request_tag;
            n_reg     <= n_load;
            empty_reg <= (server_count == '0);
            idx_reg   <= '0;
            total_reg <= '0;
        end else if (cmd.step) begin
            idx_reg   <= idx_reg + 1'b1;
            total_reg <= total_reg + swrr_pkg::weight_to_total(w_cur);
            if (better) begin
                best_reg <= rw_step;
                pick_reg <= idx_reg;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.publish) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            out_chosen_reg <= empty_reg ? '0 : swrr_pkg::idx_to_chosen(pick_reg);
            out_tag_reg    <= tag_reg;
            out_none_reg   <= empty_reg;
        end
    end

    assign sts.count_zero = (server_count == '0);
    assign sts.last       = (swrr_pkg::idx_to_count(idx_reg) == n_reg - 1'b1);
    assign sts.out_free   = !out_valid_reg || m_ready;

    assign m_valid         = out_valid_reg;
    assign m_chosen_server = out_chosen_reg;
    assign m_tag_out       = out_tag_reg;
    assign m_no_server     = out_none_reg;

endmodule
